>>> hw/rtl/ordered_record_table_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ordered record table
// Concurrent property wrappers; compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ORDERED_RECORD_TABLE_DEFINES_SVH
`define ORDERED_RECORD_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ORT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ordered_record_table: same-cycle property failed");

// next-cycle implication
`define ORT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ordered_record_table: next-cycle property failed");

`else

`define ORT_ASSERT_IMPL(label, clk, rst, ante, cons)
`define ORT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> hw/rtl/ort_pkg.sv
// ----------------------------------------------------------------------------
// Ordered record table package
// Beat types, operation and status codes, cell control and sequencer states.
// ----------------------------------------------------------------------------
package ort_pkg;

   localparam int ORT_TABLE_DEPTH = 16;
   localparam int ORT_KEY_BITS    = 16;

   // fixed field widths of the beats
   localparam int ROLL_BITS = 16;
   localparam int BATCH_BITS = 16;
   localparam int POS_BITS  = 4;
   localparam int OCC_BITS  = 5;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_SEARCH = 2'd1,
      MODE_DELETE = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef struct packed {
      mode_type              mode;
      logic                  key_select;
      logic [ROLL_BITS-1:0]  roll_number;
      logic [BATCH_BITS-1:0] batch_number;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [POS_BITS-1:0]   match_position;
      logic [ROLL_BITS-1:0]  match_roll;
      logic [BATCH_BITS-1:0] match_batch;
      logic [OCC_BITS-1:0]   occupancy;
   } rsp_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic capture;
      logic insert;
      logic remove;
      logic key_select;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_APPLY
   } state_type;

endpackage

>>> hw/rtl/ort_cell.sv
// ----------------------------------------------------------------------------
// Ordered record table cell
// Holds one record, compares it against the broadcast key, takes part in the
// oldest-match chain and loads from its younger neighbour on a removal.
// ----------------------------------------------------------------------------
module ort_cell
   import ort_pkg::*;
#(
   parameter int KEY_W = ORT_KEY_BITS
) (
   input  logic             clock,
   input  cell_ctrl_type    ctrl,
   input  logic [KEY_W-1:0] key_roll,
   input  logic [KEY_W-1:0] key_batch,
   input  logic             occupied,
   input  logic             tail,
   input  logic             seen_in,
   output logic             seen_out,
   output logic             first,
   input  logic [KEY_W-1:0] next_roll,
   input  logic [KEY_W-1:0] next_batch,
   output logic [KEY_W-1:0] roll_q,
   output logic [KEY_W-1:0] batch_q
);

   logic [KEY_W-1:0] roll_ff, roll_in;
   logic [KEY_W-1:0] batch_ff, batch_in;
   logic             hit_ff, hit_in;
   logic             match;

   // key compare on the selected field
   assign match = occupied &&
                  (ctrl.key_select ? (batch_ff == key_batch) : (roll_ff == key_roll));

   assign hit_in = ctrl.capture ? match : hit_ff;

   // oldest-match chain: first hit not preceded by an older one
   assign seen_out = seen_in | hit_ff;
   assign first    = hit_ff & ~seen_in;

   // record load: append at tail, or close the gap from the neighbour
   always_comb begin
      roll_in  = roll_ff;
      batch_in = batch_ff;
      if (ctrl.insert && tail) begin
         roll_in  = key_roll;
         batch_in = key_batch;
      end else if (ctrl.remove && seen_out) begin
         roll_in  = next_roll;
         batch_in = next_batch;
      end
   end

   always_ff @(posedge clock) begin
      roll_ff  <= roll_in;
      batch_ff <= batch_in;
      hit_ff   <= hit_in;
   end

   assign roll_q  = roll_ff;
   assign batch_q = batch_ff;

endmodule

>>> hw/rtl/ordered_record_table.sv
// ----------------------------------------------------------------------------
// Ordered record table
// Insertion-ordered table of roll/batch records with insert, search and
// delete-first-match, built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
//  Channel  Ports                   Direction  Handshake
//  request  start, busy, req_item   in         beat on start high, busy low
//  response rsp_strobe, rsp_item    out        one-cycle strobe, no back-pressure
//
//  Each beat goes through capture, parallel key compare in every cell,
//  then oldest-match resolution with table update. The response strobe rises
//  in the cycle after the update edge; busy falls in that same cycle, so a new
//  beat can be taken while the response is shown.
//  Reset clears the sequencer state, record count and response strobe only; record storage is not cleared.
//  The receiver cannot stall, so there is no output buffering beyond one beat.
// ----------------------------------------------------------------------------
`include "ordered_record_table_defines.svh"

module ordered_record_table
   import ort_pkg::*;
#(
   parameter int TABLE_DEPTH = ORT_TABLE_DEPTH,
   parameter int KEY_BITS    = ORT_KEY_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int STORE_BITS = (KEY_BITS < ROLL_BITS) ? KEY_BITS : ROLL_BITS;
   localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
   localparam int WIDE_W     = (CNT_W > OCC_BITS) ? CNT_W : OCC_BITS;

   state_type              state_ff, state_in;
   req_type                req_ff, req_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   cell_ctrl_type          ctrl;
   logic                   accept;
   logic                   full;
   logic                   found;

   logic [STORE_BITS-1:0]  key_roll, key_batch;
   logic [TABLE_DEPTH:0]   seen;
   logic [TABLE_DEPTH-1:0] first;
   logic [TABLE_DEPTH-1:0] occupied;
   logic [TABLE_DEPTH-1:0] tail;
   logic [STORE_BITS-1:0]  roll_q  [TABLE_DEPTH];
   logic [STORE_BITS-1:0]  batch_q [TABLE_DEPTH];

   logic [STORE_BITS-1:0]  sel_roll, sel_batch;
   logic [WIDE_W-1:0]      sel_pos;
   logic [WIDE_W-1:0]      pos_wide, occ_wide;

   assign accept    = start && !busy;
   assign full      = (count_ff == CNT_W'(TABLE_DEPTH));
   assign found     = seen[TABLE_DEPTH];
   assign key_roll  = req_ff.roll_number[STORE_BITS-1:0];
   assign key_batch = req_ff.batch_number[STORE_BITS-1:0];

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (start) begin
                      state_in = ST_MATCH;
                   end
         ST_MATCH: state_in = ST_APPLY;
         ST_APPLY: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      busy            = 1'b1;
      ctrl.capture    = 1'b0;
      ctrl.insert     = 1'b0;
      ctrl.remove     = 1'b0;
      ctrl.key_select = req_ff.key_select;
      rsp_valid_in    = 1'b0;
      case (state_ff)
         ST_IDLE:  busy = 1'b0;
         ST_MATCH: ctrl.capture = 1'b1;
         ST_APPLY: begin
            ctrl.insert  = (req_ff.mode == MODE_INSERT) && !full;
            ctrl.remove  = (req_ff.mode == MODE_DELETE) && found;
            rsp_valid_in = 1'b1;
         end
         default:  busy = 1'b1;
      endcase
   end

   assign req_in = accept ? req_item : req_ff;

   // per-cell occupancy and tail flags
   assign seen[0] = 1'b0;
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic [STORE_BITS-1:0] nroll, nbatch;

      assign occupied[i] = (count_ff > CNT_W'(i));
      assign tail[i]     = (count_ff == CNT_W'(i));

      if (i < TABLE_DEPTH - 1) begin : g_mid
         assign nroll  = roll_q[i+1];
         assign nbatch = batch_q[i+1];
      end else begin : g_last
         assign nroll  = roll_q[i];
         assign nbatch = batch_q[i];
      end

      ort_cell #(
         .KEY_W(STORE_BITS)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .key_roll   (key_roll),
         .key_batch  (key_batch),
         .occupied   (occupied[i]),
         .tail       (tail[i]),
         .seen_in    (seen[i]),
         .seen_out   (seen[i+1]),
         .first      (first[i]),
         .next_roll  (nroll),
         .next_batch (nbatch),
         .roll_q     (roll_q[i]),
         .batch_q    (batch_q[i])
      );
   end

   // readout of the oldest match (one-hot select)
   always_comb begin
      sel_roll  = '0;
      sel_batch = '0;
      sel_pos   = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (first[i]) begin
            sel_roll  = sel_roll  | roll_q[i];
            sel_batch = sel_batch | batch_q[i];
            sel_pos   = sel_pos   | WIDE_W'(i);
         end
      end
   end

   // response beat and count update
   always_comb begin
      count_in                = count_ff;
      pos_wide                = '0;
      rsp_in.status           = STATUS_MISS;
      rsp_in.match_roll       = '0;
      rsp_in.match_batch      = '0;
      if (state_ff == ST_APPLY) begin
         case (req_ff.mode)
            MODE_INSERT: begin
               if (full) begin
                  rsp_in.status = STATUS_FULL;
               end else begin
                  rsp_in.status      = STATUS_OK;
                  pos_wide           = WIDE_W'(count_ff);
                  rsp_in.match_roll  = ROLL_BITS'(key_roll);
                  rsp_in.match_batch = BATCH_BITS'(key_batch);
                  count_in           = count_ff + 1'b1;
               end
            end
            MODE_SEARCH, MODE_DELETE: begin
               if (found) begin
                  rsp_in.status      = STATUS_OK;
                  pos_wide           = sel_pos;
                  rsp_in.match_roll  = ROLL_BITS'(sel_roll);
                  rsp_in.match_batch = BATCH_BITS'(sel_batch);
                  if (req_ff.mode == MODE_DELETE) begin
                     count_in = count_ff - 1'b1;
                  end
               end
            end
            default: rsp_in.status = STATUS_MISS;
         endcase
      end
      occ_wide              = WIDE_W'(count_in);
      rsp_in.match_position = pos_wide[POS_BITS-1:0];
      rsp_in.occupancy      = occ_wide[OCC_BITS-1:0];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      if (rsp_valid_in) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   // checks
   `ORT_ASSERT_NEXT(a_strobe_after_apply, clock, reset, state_ff == ST_APPLY, rsp_valid_ff)
   `ORT_ASSERT_NEXT(a_count_held, clock, reset, state_ff != ST_APPLY, $stable(count_ff))
   `ORT_ASSERT_NEXT(a_insert_grows, clock, reset, ctrl.insert, count_ff == $past(count_ff) + 1'b1)
   `ORT_ASSERT_IMPL(a_first_onehot, clock, reset, state_ff == ST_APPLY, $onehot0(first))

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Ordered record table testbench
// Sends insert, search and delete beats through the start/busy handshake,
// keeps a shadow copy of the table to work out each response, and checks
// every strobed response in order against that shadow copy.
// ---------------------------------------------------------------------------
module tb_top
   import ort_pkg::*;
;

   localparam int CLK_HALF     = 5;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 16;
   localparam int DEPTH        = ORT_TABLE_DEPTH;
   localparam int RANDOM_BEATS = 1300;
   localparam logic [ROLL_BITS-1:0] KEY_MASK = ROLL_BITS'((64'd1 << ORT_KEY_BITS) - 64'd1);

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   // shadow of the table contents
   logic [ROLL_BITS-1:0]  shadow_roll  [DEPTH];
   logic [BATCH_BITS-1:0] shadow_batch [DEPTH];
   int                    shadow_held = 0;

   rsp_type op_results_due[$];
   int      fault_count = 0;
   int      idle_cycles = 0;
   int      gap_max     = 3;

   ordered_record_table uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #CLK_HALF clock = ~clock;

   // apply one operation to the shadow table and return its response
   function automatic rsp_type table_op_result(req_type op);
      rsp_type               res;
      logic [ROLL_BITS-1:0]  roll;
      logic [BATCH_BITS-1:0] batch;
      int                    hit;
      res        = '0;
      res.status = STATUS_MISS;
      roll       = op.roll_number & KEY_MASK;
      batch      = op.batch_number & KEY_MASK;
      hit        = -1;
      case (op.mode)
         MODE_INSERT: begin
            if (shadow_held >= DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               shadow_roll[shadow_held]  = roll;
               shadow_batch[shadow_held] = batch;
               res.status         = STATUS_OK;
               res.match_position = POS_BITS'(shadow_held);
               res.match_roll     = roll;
               res.match_batch    = batch;
               shadow_held++;
            end
         end
         MODE_SEARCH, MODE_DELETE: begin
            // oldest match wins
            for (int i = 0; i < shadow_held; i++) begin
               if (hit < 0 && (op.key_select ? shadow_batch[i] == batch
                                             : shadow_roll[i] == roll))
                  hit = i;
            end
            if (hit >= 0) begin
               res.status         = STATUS_OK;
               res.match_position = POS_BITS'(hit);
               res.match_roll     = shadow_roll[hit];
               res.match_batch    = shadow_batch[hit];
               if (op.mode == MODE_DELETE) begin
                  for (int i = hit; i + 1 < shadow_held; i++) begin
                     shadow_roll[i]  = shadow_roll[i + 1];
                     shadow_batch[i] = shadow_batch[i + 1];
                  end
                  shadow_held--;
               end
            end
         end
         default: ;
      endcase
      res.occupancy = OCC_BITS'(shadow_held);
      return res;
   endfunction

   function automatic req_type make_req(mode_type m, logic ks, logic [ROLL_BITS-1:0] roll,
                                        logic [BATCH_BITS-1:0] batch);
      req_type r;
      r.mode         = m;
      r.key_select   = ks;
      r.roll_number  = roll;
      r.batch_number = batch;
      return r;
   endfunction

   // keys half the time from what the table holds, so searches and deletes hit
   function automatic logic [15:0] pick_key(bit want_batch);
      int sel;
      int slot;
      sel = $urandom_range(0, 3);
      if (sel < 2 && shadow_held > 0) begin
         slot = $urandom_range(0, shadow_held - 1);
         return want_batch ? shadow_batch[slot] : shadow_roll[slot];
      end else if (sel == 2) begin
         return 16'($urandom_range(0, 7));
      end
      return 16'($urandom);
   endfunction

   // one request beat: optional gap, then hold start until busy is low
   task automatic send_beat(req_type item);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy);
      op_results_due.push_back(table_op_result(item));
   endtask

   task automatic report_fault(string what, rsp_type got, rsp_type want);
      fault_count++;
      if (fault_count <= 10) begin
         $display("%0t: %s: expected st=%0d pos=%0d roll=%h batch=%h occ=%0d",
                  $realtime, what, want.status, want.match_position, want.match_roll,
                  want.match_batch, want.occupancy);
         $display("%0t: %s: got      st=%0d pos=%0d roll=%h batch=%h occ=%0d",
                  $realtime, what, got.status, got.match_position, got.match_roll,
                  got.match_batch, got.occupancy);
      end
   endtask

   // response check against the oldest outstanding beat
   always @(posedge clock) begin
      rsp_type due;
      if (!reset && rsp_strobe) begin
         if (op_results_due.size() == 0) begin
            report_fault("response with no beat outstanding", rsp_item, '0);
         end else begin
            due = op_results_due.pop_front();
            if (rsp_item.status !== due.status ||
                rsp_item.match_position !== due.match_position ||
                rsp_item.match_roll !== due.match_roll ||
                rsp_item.match_batch !== due.match_batch ||
                rsp_item.occupancy !== due.occupancy)
               report_fault("response mismatch", rsp_item, due);
         end
      end
   end

   // watchdog: cycles with neither a request nor a response beat
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("** ordered_record_table: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // searching and deleting an empty table, and the unused mode
   task automatic test_empty_table();
      send_beat(make_req(MODE_SEARCH, 1'b0, 16'h0000, 16'h0000));
      send_beat(make_req(MODE_DELETE, 1'b1, 16'hFFFF, 16'hFFFF));
      send_beat(make_req(MODE_NONE, 1'b1, 16'hFFFF, 16'hFFFF));
   endtask

   // fill to capacity with extreme and repeated keys, then overflow
   task automatic test_fill_to_full();
      send_beat(make_req(MODE_INSERT, 1'b0, 16'h0000, 16'hFFFF));
      send_beat(make_req(MODE_INSERT, 1'b1, 16'hFFFF, 16'h0000));
      for (int i = 2; i < DEPTH; i++)
         send_beat(make_req(MODE_INSERT, 1'(i), 16'h0100 + 16'(i % 4), 16'h0200 + 16'(i % 5)));
      send_beat(make_req(MODE_INSERT, 1'b0, 16'hFFFF, 16'hFFFF));
   endtask

   // oldest of several matches, delete from the middle and the head, miss
   task automatic test_match_rules();
      send_beat(make_req(MODE_SEARCH, 1'b0, 16'h0101, 16'h0000));
      send_beat(make_req(MODE_SEARCH, 1'b1, 16'hFFFF, 16'h0202));
      send_beat(make_req(MODE_DELETE, 1'b1, 16'h0000, 16'h0203));
      send_beat(make_req(MODE_DELETE, 1'b0, 16'h0000, 16'h1234));
      send_beat(make_req(MODE_SEARCH, 1'b0, 16'hBEEF, 16'hBEEF));
   endtask

   // alternating fill-heavy and drain-heavy blocks, some with no gaps
   task automatic test_random_traffic(int n_beats);
      int       ins_pct;
      int       sel;
      mode_type m;
      for (int k = 0; k < n_beats; k++) begin
         ins_pct = ((k / 100) % 2 == 0) ? 70 : 25;
         gap_max = ((k / 100) % 4 == 3) ? 0 : 3;
         sel     = $urandom_range(0, 99);
         if (sel < 3)
            m = MODE_NONE;
         else if (sel < 3 + ins_pct)
            m = MODE_INSERT;
         else if (sel % 2 != 0)
            m = MODE_SEARCH;
         else
            m = MODE_DELETE;
         send_beat(make_req(m, 1'($urandom), pick_key(1'b0), pick_key(1'b1)));
      end
      gap_max = 3;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_fill_to_full();
      test_match_rules();
      test_random_traffic(RANDOM_BEATS);
      start <= 1'b0;
      while (op_results_due.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0 && op_results_due.size() == 0) begin
         $display("** ordered_record_table: PASSED **");
      end else begin
         $display("** ordered_record_table: FAILED **");
      end
      $finish;
   end

endmodule
